FILE: sv/bsi_pkg.sv
package bsi_pkg;

  localparam int PIXEL_BITS   = 10;
  localparam int MAX_WIDTH    = 128;
  localparam int PAD_COLUMNS  = 4;
  localparam int HEIGHT_LIMIT = 128;
  localparam int STORE_DEPTH  = MAX_WIDTH + PAD_COLUMNS + 1;
  localparam int SAMPLE_BITS  = 16;
  localparam int COUNT_BITS   = 8;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);

  // filter_mode bits
  localparam int MODE_HOR_BIT = 0;
  localparam int MODE_VER_BIT = 1;

  // register indexes
  localparam logic [2:0] REG_FILTER_MODE  = 3'd0;
  localparam logic [2:0] REG_PACKED_FRAC  = 3'd1;
  localparam logic [2:0] REG_BLOCK_WIDTH  = 3'd2;
  localparam logic [2:0] REG_BLOCK_HEIGHT = 3'd3;
  localparam logic [2:0] REG_UP_SHIFT     = 3'd4;

  typedef struct packed {
    logic [1:0] filter_mode;
    logic [7:0] packed_fraction;
    logic [7:0] block_width;
    logic [7:0] block_height;
    logic [1:0] up_shift;
  } cfg_t;

  // one transaction from front to back
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] val;
    logic [COUNT_BITS-1:0]  oc;
    logic                   ver;
    logic                   fill;
    logic                   row_end;
    logic                   block_end;
  } entry_t;

endpackage

FILE: sv/bilinear_subpel_interpolator.sv
// Bilinear sixteenth-pel interpolator.
// Input channel (in_valid/in_ready/in_pixel): reference pixels in raster order,
//   one transaction per clock while in_ready is high. Each row carries W =
//   block_width + 4 pixels, one more when the mode filters horizontally;
//   H rows, one more when it filters vertically. The first pixel of a row
//   (horizontal) and the whole first row (vertical) produce no output.
// Output channel (out_valid/out_ready/out_sample/out_row_end/out_block_end):
//   one filtered sample per producing input, flags on the last of a row/block.
// Path: input, queue, back stage register, output register. Throughput: 1 input
//   per clock while out_ready is high; the front filter, the 4-entry queue and
//   the back stage with its single-port line store each handle one per cycle.
// APB registers at 4*i: mode, fraction, width, height, up_shift. pready is
//   tied high; any register write restarts the block counters. Write only idle.
// Reset (rst_n, synchronous): counters, previous pixel, queue and output valid
//   cleared, registers to defaults. The line store is not cleared; every read
//   of it whose value is used follows a write in the same block.
// Receiver stall: the output register holds; the back stage and queue absorb
//   up to 5 transactions, then in_ready drops until out_ready returns.
module bilinear_subpel_interpolator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  in_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_sample,
  output logic        out_row_end,
  output logic        out_block_end
);
  import bsi_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en, restart;
  logic [2:0] reg_idx;

  logic       q_push, q_full, q_pop, q_empty;
  entry_t     q_in, q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // writes beyond the register list are dropped and do not restart
  always_comb begin
    restart = 1'b0;
    unique case (reg_idx)
      REG_FILTER_MODE, REG_PACKED_FRAC, REG_BLOCK_WIDTH,
      REG_BLOCK_HEIGHT, REG_UP_SHIFT: restart = wr_en;
      default: restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_mode     <= 2'd0;
      cfg_r.packed_fraction <= 8'd0;
      cfg_r.block_width     <= 8'd8;
      cfg_r.block_height    <= 8'd8;
      cfg_r.up_shift        <= 2'd2;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FILTER_MODE:  cfg_r.filter_mode     <= pwdata[1:0];
        REG_PACKED_FRAC:  cfg_r.packed_fraction <= pwdata[7:0];
        REG_BLOCK_WIDTH:  cfg_r.block_width     <= pwdata[7:0];
        REG_BLOCK_HEIGHT: cfg_r.block_height    <= pwdata[7:0];
        REG_UP_SHIFT:     cfg_r.up_shift        <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_FILTER_MODE:  prdata = 32'(cfg_r.filter_mode);
      REG_PACKED_FRAC:  prdata = 32'(cfg_r.packed_fraction);
      REG_BLOCK_WIDTH:  prdata = 32'(cfg_r.block_width);
      REG_BLOCK_HEIGHT: prdata = 32'(cfg_r.block_height);
      REG_UP_SHIFT:     prdata = 32'(cfg_r.up_shift);
      default:          prdata = '0;
    endcase
  end

  // front: counters, horizontal tap, classification
  bsi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .restart  (restart),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pixel (in_pixel),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  bsi_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // back: line store, vertical tap, output register
  bsi_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample    (out_sample),
    .out_row_end   (out_row_end),
    .out_block_end (out_block_end)
  );

endmodule

FILE: sv/bsi_front.sv
module bsi_front (
  input  logic            clk,
  input  logic            rst_n,
  input  bsi_pkg::cfg_t   cfg,
  input  logic            restart,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [9:0]      in_pixel,
  input  logic            q_full,
  output logic            q_push,
  output bsi_pkg::entry_t q_entry
);
  import bsi_pkg::*;

  logic [COUNT_BITS-1:0] col_r, col_nxt;
  logic [COUNT_BITS-1:0] row_r, row_nxt;
  logic [PIXEL_BITS-1:0] prev_r, prev_nxt;

  logic                  hor, ver, accept, have;
  logic [COUNT_BITS-1:0] wcl, w, in_len, hcl, rows, oc;
  logic [3:0]            fh;
  logic [2:0]            sh;
  logic [4:0]            wa;
  logic [14:0]           hsum, hoff;
  logic [SAMPLE_BITS-1:0] val;
  logic                  re;

  assign hor = cfg.filter_mode[MODE_HOR_BIT];
  assign ver = cfg.filter_mode[MODE_VER_BIT];

  always_comb begin
    if (cfg.block_width == '0) begin
      wcl = COUNT_BITS'(1);
    end else if (cfg.block_width > COUNT_BITS'(MAX_WIDTH)) begin
      wcl = COUNT_BITS'(MAX_WIDTH);
    end else begin
      wcl = cfg.block_width;
    end
    if (cfg.block_height == '0) begin
      hcl = COUNT_BITS'(1);
    end else if (cfg.block_height > COUNT_BITS'(HEIGHT_LIMIT)) begin
      hcl = COUNT_BITS'(HEIGHT_LIMIT);
    end else begin
      hcl = cfg.block_height;
    end
  end

  assign w      = wcl + COUNT_BITS'(PAD_COLUMNS);
  assign in_len = w + COUNT_BITS'(hor);
  assign rows   = hcl + COUNT_BITS'(ver);

  assign fh   = cfg.packed_fraction[3:0];
  assign sh   = 3'd4 - {1'b0, cfg.up_shift};
  assign wa   = 5'd16 - {1'b0, fh};
  assign hoff = 15'd1 << (sh - 3'd1);
  assign hsum = 15'(prev_r) * 15'(wa) + 15'(in_pixel) * 15'(fh) + hoff;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    prev_nxt = prev_r;
    oc       = col_r;
    have     = 1'b1;
    if (hor) begin
      val      = SAMPLE_BITS'(hsum >> sh);
      oc       = col_r - COUNT_BITS'(1);
      have     = (col_r != '0);
      prev_nxt = in_pixel;
    end else if (ver) begin
      val = SAMPLE_BITS'(in_pixel);
    end else begin
      val = SAMPLE_BITS'(in_pixel) << cfg.up_shift;
    end
  end

  assign re = (oc + COUNT_BITS'(1) == w);

  always_comb begin
    col_nxt = col_r + COUNT_BITS'(1);
    row_nxt = row_r;
    if (col_nxt >= in_len) begin
      col_nxt = '0;
      row_nxt = row_r + COUNT_BITS'(1);
      if (row_nxt >= rows) begin
        row_nxt = '0;
      end
    end
  end

  assign q_push            = accept && have;
  assign q_entry.val       = val;
  assign q_entry.oc        = oc;
  assign q_entry.ver       = ver;
  assign q_entry.fill      = ver && (row_r == '0);
  assign q_entry.row_end   = re;
  assign q_entry.block_end = re && (row_r + COUNT_BITS'(1) == rows);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      prev_r <= '0;
    end else begin
      if (restart) begin
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        prev_r <= prev_nxt;
      end
    end
  end

endmodule

FILE: sv/bsi_fifo.sv
module bsi_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bsi_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output bsi_pkg::entry_t head
);
  import bsi_pkg::*;

  entry_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QPTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: sv/bsi_back.sv
module bsi_back (
  input  logic            clk,
  input  logic            rst_n,
  input  bsi_pkg::cfg_t   cfg,
  input  logic            q_empty,
  input  bsi_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     out_sample,
  output logic            out_row_end,
  output logic            out_block_end
);
  import bsi_pkg::*;

  // line store of the previous row, read before write at the same column
  logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] above_r;

  logic                   s1_v_r, s1_v_nxt;
  entry_t                 s1_r;
  logic                   o_v_r, o_v_nxt;
  logic [SAMPLE_BITS-1:0] o_sample_r;
  logic                   o_re_r, o_be_r;

  logic                   s1_adv;
  logic [3:0]             fv;
  logic [4:0]             wv;
  logic [2:0]             shv;
  logic [21:0]            vsum, voff;
  logic [SAMPLE_BITS-1:0] res;

  assign fv   = cfg.packed_fraction[7:4];
  assign wv   = 5'd16 - {1'b0, fv};
  assign shv  = cfg.filter_mode[MODE_HOR_BIT] ? 3'd4 : (3'd4 - {1'b0, cfg.up_shift});
  assign voff = 22'd1 << (shv - 3'd1);
  assign vsum = 22'(above_r) * 22'(wv) + 22'(s1_r.val) * 22'(fv) + voff;
  assign res  = s1_r.ver ? SAMPLE_BITS'(vsum >> shv) : s1_r.val;

  // fill transactions only load the line store and retire without output
  assign s1_adv   = s1_v_r && (s1_r.fill || !o_v_r || out_ready);
  assign q_pop    = !q_empty && (!s1_v_r || s1_adv);
  assign s1_v_nxt = q_pop ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);

  always_comb begin
    o_v_nxt = o_v_r;
    if (s1_adv && !s1_r.fill) begin
      o_v_nxt = 1'b1;
    end else if (out_ready) begin
      o_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      above_r <= mem[q_head.oc];
      s1_r    <= q_head;
      if (q_head.ver) begin
        mem[q_head.oc] <= q_head.val;
      end
    end
    if (s1_adv && !s1_r.fill) begin
      o_sample_r <= res;
      o_re_r     <= s1_r.row_end;
      o_be_r     <= s1_r.block_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  assign out_valid     = o_v_r;
  assign out_sample    = o_sample_r;
  assign out_row_end   = o_re_r;
  assign out_block_end = o_be_r;

endmodule
